// File: src/pdda_pkg.sv
// shared types and constants for the poisson disk dart accept block
// no dependencies; compiled first
`default_nettype none

package pdda_pkg;

    localparam int COORD_W     = 16;
    localparam int POINT_W     = 3 * COORD_W;
    localparam int MIN_DIST_W  = 33;
    localparam int TARGET_W    = 9;
    localparam int COUNT_OUT_W = 9;
    localparam int MAG_W       = COORD_W;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 4;

    localparam logic [MIN_DIST_W-1:0] MIN_DIST_RESET = 33'd32719000;
    localparam logic [TARGET_W-1:0]   TARGET_RESET   = 9'd256;

    // register index taken from address bit 3 (registers sit 8 bytes apart)
    typedef enum logic
    {
        REG_MIN_DIST = 1'b0,
        REG_TARGET   = 1'b1
    } cfg_reg_t;

    typedef struct packed
    {
        logic valid;
        logic flush;
    } dist_ctl_t;

    typedef struct packed
    {
        logic valid;
        logic conflict;
    } dist_res_t;

endpackage

`default_nettype wire

// File: src/pdda_if.sv
// valid/ready channel interfaces for candidate points and results
// depends on pdda_pkg
`default_nettype none

interface pdda_point_if;
    logic                               valid;
    logic                               ready;
    logic signed [pdda_pkg::COORD_W-1:0] point_x;
    logic signed [pdda_pkg::COORD_W-1:0] point_y;
    logic signed [pdda_pkg::COORD_W-1:0] point_z;
    logic                               start_new;

    modport source (output valid, point_x, point_y, point_z, start_new, input ready);
    modport sink   (input valid, point_x, point_y, point_z, start_new, output ready);
endinterface

interface pdda_result_if;
    logic                                valid;
    logic                                ready;
    logic                                accepted;
    logic [pdda_pkg::COUNT_OUT_W-1:0]    stored_count;
    logic                                full_res;

    modport source (output valid, accepted, stored_count, full_res, input ready);
    modport sink   (input valid, accepted, stored_count, full_res, output ready);
endinterface

`default_nettype wire

// File: src/pdda_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module pdda_ram #(
    parameter  int WIDTH = 48,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/pdda_cfg.sv
// apb register file: squared rejection radius and target count
// depends on pdda_pkg
`default_nettype none

module pdda_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pdda_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [pdda_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [pdda_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output logic      [pdda_pkg::MIN_DIST_W-1:0]     min_dist_sq,
    output logic      [pdda_pkg::TARGET_W-1:0]       target_count
);

    logic                              wr_en;
    pdda_pkg::cfg_reg_t                reg_sel;
    logic [pdda_pkg::MIN_DIST_W-1:0]   min_dist_reg;
    logic [pdda_pkg::TARGET_W-1:0]     target_reg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = pdda_pkg::cfg_reg_t'(paddr[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= pdda_pkg::MIN_DIST_RESET;
            target_reg   <= pdda_pkg::TARGET_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                pdda_pkg::REG_MIN_DIST: min_dist_reg <= pwdata[pdda_pkg::MIN_DIST_W-1:0];
                pdda_pkg::REG_TARGET:   target_reg   <= pwdata[pdda_pkg::TARGET_W-1:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            pdda_pkg::REG_MIN_DIST: prdata = pdda_pkg::APB_DATA_W'(min_dist_reg);
            pdda_pkg::REG_TARGET:   prdata = pdda_pkg::APB_DATA_W'(target_reg);
            default:                prdata = '0;
        endcase
    end

    assign min_dist_sq  = min_dist_reg;
    assign target_count = target_reg;

endmodule

`default_nettype wire

// File: src/pdda_dist.sv
// three-stage squared distance pipeline with radius compare
// depends on pdda_pkg
`default_nettype none

module pdda_dist (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire pdda_pkg::dist_ctl_t                  ctl,
    input  wire logic signed [pdda_pkg::COORD_W-1:0]  cand_x,
    input  wire logic signed [pdda_pkg::COORD_W-1:0]  cand_y,
    input  wire logic signed [pdda_pkg::COORD_W-1:0]  cand_z,
    input  wire logic        [pdda_pkg::POINT_W-1:0]  stored,
    input  wire logic        [pdda_pkg::MIN_DIST_W-1:0] min_dist_sq,
    output pdda_pkg::dist_res_t                       res
);

    localparam int CW = pdda_pkg::COORD_W;
    localparam int MW = pdda_pkg::MAG_W;
    localparam int QW = pdda_pkg::SQ_W;
    localparam int SW = pdda_pkg::SUM_W;

    logic signed [CW:0]   dx, dy, dz;
    logic [MW-1:0]        mag_x_next, mag_y_next, mag_z_next;
    logic [MW-1:0]        mag_x_reg, mag_y_reg, mag_z_reg;
    logic [QW-1:0]        sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SW-1:0]        sum;
    logic                 v1_reg, v2_reg, v3_reg, conflict_reg;

    // difference of two q1.15 values needs 17 bits; its magnitude fits 16
    assign dx = {cand_x[CW-1], cand_x} - {stored[3*CW-1], stored[3*CW-1:2*CW]};
    assign dy = {cand_y[CW-1], cand_y} - {stored[2*CW-1], stored[2*CW-1:CW]};
    assign dz = {cand_z[CW-1], cand_z} - {stored[CW-1], stored[CW-1:0]};

    always_comb
    begin
        mag_x_next = dx[CW] ? MW'(-dx) : MW'(dx);
        mag_y_next = dy[CW] ? MW'(-dy) : MW'(dy);
        mag_z_next = dz[CW] ? MW'(-dz) : MW'(dz);
    end

    assign sum = SW'(sq_x_reg) + SW'(sq_y_reg) + SW'(sq_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.valid && !ctl.flush;
            v2_reg <= v1_reg && !ctl.flush;
            v3_reg <= v2_reg && !ctl.flush;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_x_reg    <= mag_x_next;
        mag_y_reg    <= mag_y_next;
        mag_z_reg    <= mag_z_next;
        sq_x_reg     <= QW'(mag_x_reg) * QW'(mag_x_reg);
        sq_y_reg     <= QW'(mag_y_reg) * QW'(mag_y_reg);
        sq_z_reg     <= QW'(mag_z_reg) * QW'(mag_z_reg);
        conflict_reg <= sum < SW'(min_dist_sq);
    end

    assign res.valid    = v3_reg;
    assign res.conflict = conflict_reg;

endmodule

`default_nettype wire

// File: src/poisson_disk_dart_accept_core.sv
// top level of the poisson disk dart acceptance block: sequencer, point store, apb registers
// depends on pdda_pkg, pdda_if, pdda_ram, pdda_dist, pdda_cfg
`default_nettype none

// Dart-throwing acceptance test for Poisson-disk sampling on the unit sphere.
// Each beat on the point channel carries one candidate (x, y, z in signed
// Q1.15). The candidate is compared against every point stored so far using
// the squared Euclidean distance in units of 2^-30; if no stored point lies
// strictly inside min_dist_sq, it is appended to the store. Once the stored
// count reaches min(target_count, MAX_POINTS) every further candidate
// without start_new is rejected and full_res reads 1. start_new empties
// the store before the candidate is tested. Stored points live in a single
// ram with registered reads; one stored point is read per cycle and fed to
// a three-stage squared-distance pipeline. With no conflict the candidate
// is appended once every stored point has returned its result (at once
// with an empty store); a full set skips the scan, and a conflict on a
// stored point ends it early. The result register then loads in ST_FINISH,
// and the next candidate is taken in the cycle after it loads. One item is
// processed at a time; a finished result sits in an output register, so the
// next candidate is taken while the previous result waits on the result
// channel. The store needs no clearing pass: only entries below the count are ever read.
// Registers sit on the apb port at byte 0 (min_dist_sq, 33 bits) and byte 8
// (target_count, 9 bits); write them only while the block is idle.

module poisson_disk_dart_accept_core #(
    parameter int MAX_POINTS = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    pdda_point_if.sink                            point,
    pdda_result_if.source                         result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pdda_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [pdda_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [pdda_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    // count must hold MAX_POINTS itself; compare width also covers target_count
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CMP_W  = (CNT_W > pdda_pkg::TARGET_W) ? CNT_W : pdda_pkg::TARGET_W;
    localparam int CW     = pdda_pkg::COORD_W;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // configuration
    logic [pdda_pkg::MIN_DIST_W-1:0] min_dist_sq;
    logic [pdda_pkg::TARGET_W-1:0]   target_count;
    logic [CMP_W-1:0]                tgt;

    // sequencer state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic [CNT_W-1:0]  done_reg, done_next;
    logic              acc_reg, acc_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_acc_reg, out_acc_next;
    logic [pdda_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic              out_full_reg, out_full_next;

    // candidate held for the duration of the scan
    logic signed [CW-1:0] cand_x_reg, cand_y_reg, cand_z_reg;

    logic              in_fire;
    logic [CNT_W-1:0]  cnt_eff;
    logic              rd_en;
    logic              ram_we;
    logic              conflict_now;
    logic [CMP_W-1:0]  count_ext;
    logic [pdda_pkg::POINT_W-1:0] rd_data;

    pdda_pkg::dist_ctl_t dist_ctl;
    pdda_pkg::dist_res_t dist_res;

    pdda_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .min_dist_sq  (min_dist_sq),
        .target_count (target_count)
    );

    // effective target: never beyond the store depth
    assign tgt = (CMP_W'(target_count) < CMP_W'(MAX_POINTS)) ? CMP_W'(target_count)
                                                             : CMP_W'(MAX_POINTS);

    assign point.ready = (state_reg == ST_IDLE);
    assign in_fire     = point.valid && point.ready;
    assign cnt_eff     = point.start_new ? '0 : count_reg;
    assign count_ext   = CMP_W'(count_reg);

    // one read per cycle until every stored point has been issued
    assign rd_en        = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign conflict_now = dist_res.valid && dist_res.conflict;
    // all results back without a conflict: append at the current count
    assign ram_we       = (state_reg == ST_SCAN) && !conflict_now && (done_reg == count_reg);

    // stale pipeline contents from an early exit are dropped outside the scan
    assign dist_ctl.valid = rd_valid_reg;
    assign dist_ctl.flush = (state_reg != ST_SCAN);

    pdda_ram #(
        .WIDTH (pdda_pkg::POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({cand_x_reg, cand_y_reg, cand_z_reg}),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    pdda_dist u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (dist_ctl),
        .cand_x      (cand_x_reg),
        .cand_y      (cand_y_reg),
        .cand_z      (cand_z_reg),
        .stored      (rd_data),
        .min_dist_sq (min_dist_sq),
        .res         (dist_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        done_next      = done_reg;
        acc_next       = acc_reg;
        rd_valid_next  = rd_en;
        out_valid_next = out_valid_reg;
        out_acc_next   = out_acc_reg;
        out_count_next = out_count_reg;
        out_full_next  = out_full_reg;

        // result beat taken downstream
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    count_next = cnt_eff;
                    issue_next = '0;
                    done_next  = '0;
                    acc_next   = 1'b0;
                    // full set: reject without touching the store
                    if (CMP_W'(cnt_eff) < tgt)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (dist_res.valid)
                begin
                    done_next = done_reg + CNT_W'(1);
                end
                if (conflict_now)
                begin
                    acc_next   = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (ram_we)
                begin
                    count_next = count_reg + CNT_W'(1);
                    acc_next   = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_count_next = count_ext[pdda_pkg::COUNT_OUT_W-1:0];
                    out_full_next  = (count_ext >= tgt);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            done_reg      <= '0;
            acc_reg       <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_count_reg <= '0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            done_reg      <= done_next;
            acc_reg       <= acc_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            out_acc_reg   <= out_acc_next;
            out_count_reg <= out_count_next;
            out_full_reg  <= out_full_next;
        end
    end

    // candidate latched on the accepted beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cand_x_reg <= point.point_x;
            cand_y_reg <= point.point_y;
            cand_z_reg <= point.point_z;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.accepted     = out_acc_reg;
    assign result.stored_count = out_count_reg;
    assign result.full_res     = out_full_reg;

`ifndef SYNTHESIS
    // the store never holds more points than it has entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    // an append grows the count by exactly one
    a_append_inc: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not advance the count");

    // results returned never outrun reads issued, reads never outrun the count
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (done_reg <= issue_reg) && (issue_reg <= count_reg))
        else $error("scan counters out of order");

    // an append is only made below the effective target
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_ext < tgt))
        else $error("append into a full set");
`endif

endmodule

`default_nettype wire
